@@ hw/rtl/rlf_pkg.sv @@
package rlf_pkg;

  // field and register widths
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 24;
  localparam int FLOOR_W  = 25;
  localparam int LEVEL_W  = 32;
  localparam int CFG_W    = 25;
  localparam int IDX_W    = 2;

  // quotient of (sample^2 * 4) / level needs 49 bits, padded to an even count
  localparam int QUO_W    = 50;
  // multiplier operands: 3x the difference, and the product accumulator
  localparam int TRI_W    = QUO_W + 2;
  localparam int ACC_W    = QUO_W + 3;

  // two quotient bits per cycle, two coefficient bits per cycle
  localparam int DIV_STEPS = QUO_W / 2;
  localparam int MUL_STEPS = COEF_W / 2;
  localparam int CNT_W     = 5;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_COEF  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FLOOR = 2'd1;

  // reset values
  localparam logic [COEF_W-1:0]  COEF_RESET  = 24'd1747;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 25'd1678;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 32'd1678;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIVIDE,
    ST_DIFF,
    ST_TRIPLE,
    ST_MULT,
    ST_FINISH
  } rlf_state_t;

endpackage

@@ hw/rtl/rms_level_follower_unit.sv @@
// RMS level follower: tracks a running RMS level of a signed Q1.23 audio
// stream with a leaky integrator around a one-step Newton square root.
//
// Input channel (in_valid / in_stall): one sample plus an end_of_block flag
// per item. Output channel (out_valid / out_stall): the updated Q8.24 level
// and block_done, which repeats the item's end_of_block flag.
// Configuration: cfg_write with cfg_index 0 loads smoothing_coef, index 1
// loads floor_level; other indexes are ignored. Write only while idle.
// Sequence: an accepted item is squared, divided by a radix-4 restoring
// divider (two quotient bits per cycle), the difference and its triple
// are formed, then it is scaled by a radix-4 shift-add multiplier (two
// coefficient bits per cycle), and the level is updated, saturated and
// registered on the output.
// No new item is taken until the last one is through the serial divider
// and multiplier, which are shared by one item at a time.
// The output register holds a result while the receiver stalls; a new item
// is accepted and worked on meanwhile, and waits in its last cycle until
// the output register is free.
// Reset (rst, synchronous): level state 1678, coefficient 1747, floor 1678,
// no result pending.
module rms_level_follower_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rlf_pkg::SAMPLE_W-1:0] sample,
  input  logic                                end_of_block,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [rlf_pkg::LEVEL_W-1:0]  level,
  output logic                                block_done,
  input  logic                                cfg_write,
  input  logic        [rlf_pkg::IDX_W-1:0]    cfg_index,
  input  logic        [rlf_pkg::CFG_W-1:0]    cfg_data
);
  import rlf_pkg::*;

  rlf_state_t state, state_next;

  logic [COEF_W-1:0]   coef;
  logic [FLOOR_W-1:0]  floor_cfg;
  logic [LEVEL_W-1:0]  running_level;

  logic [SAMPLE_W-1:0] sample_mag;
  logic                eob;
  logic [LEVEL_W-1:0]  lvl;
  logic [QUO_W-1:0]    dq;
  logic [LEVEL_W-1:0]  rem;
  logic [CNT_W-1:0]    cnt;
  logic                d_pos;
  logic [QUO_W-1:0]    dmag;
  logic [TRI_W-1:0]    d3;
  logic [COEF_W-1:0]   coef_sh;
  logic [ACC_W-1:0]    acc;

  logic                in_accept;
  logic                out_free;
  logic                fin_fire;
  logic [LEVEL_W-1:0]  flr;
  logic [SAMPLE_W-1:0] mag_in;
  logic [2*SAMPLE_W-1:0] sq;

  // divider step signals
  logic [LEVEL_W:0]    t1, t2, r1, r2;
  logic                q1, q2;

  // multiplier and update signals
  logic [TRI_W-1:0]    addend;
  logic [ACC_W-1:0]    mul_sum;
  logic [QUO_W-1:0]    m;
  logic [QUO_W:0]      up_sum;
  logic [LEVEL_W-1:0]  nv;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign fin_fire  = (state == ST_FINISH) && out_free;

  // floor of zero acts as one
  assign flr    = (floor_cfg == '0) ? LEVEL_W'(1) : LEVEL_W'(floor_cfg);
  // magnitude of a two's complement sample, full negative maps to 2^23
  assign mag_in = sample[SAMPLE_W-1] ? (~$unsigned(sample) + SAMPLE_W'(1))
                                     : $unsigned(sample);

  // full-width square of the sample magnitude
  assign sq = (2*SAMPLE_W)'(sample_mag) * (2*SAMPLE_W)'(sample_mag);

  // two restoring division steps per cycle
  always_comb begin
    t1 = {rem, dq[QUO_W-1]};
    q1 = (t1 >= {1'b0, lvl});
    r1 = q1 ? (t1 - {1'b0, lvl}) : t1;
    t2 = {r1[LEVEL_W-1:0], dq[QUO_W-2]};
    q2 = (t2 >= {1'b0, lvl});
    r2 = q2 ? (t2 - {1'b0, lvl}) : t2;
  end

  // radix-4 shift-add: pick 0, d, 2d or 3d by two coefficient bits
  always_comb begin
    unique case (coef_sh[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, dmag};
      2'd2:    addend = {1'b0, dmag, 1'b0};
      default: addend = d3;
    endcase
    mul_sum = acc + {1'b0, addend};
  end

  // new level: saturating add or clamped subtract
  always_comb begin
    m      = acc[QUO_W-1:0];
    up_sum = {(QUO_W + 1 - LEVEL_W)'(0), lvl} + {1'b0, m};
    if (d_pos) begin
      nv = (|up_sum[QUO_W:LEVEL_W]) ? '1 : up_sum[LEVEL_W-1:0];
    end else if (m >= {(QUO_W - LEVEL_W)'(0), lvl}) begin
      nv = '0;
    end else begin
      nv = lvl - m[LEVEL_W-1:0];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_accept) state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_DIVIDE;
      ST_DIVIDE: if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_TRIPLE;
      ST_TRIPLE: state_next = ST_MULT;
      ST_MULT:   if (cnt == CNT_W'(MUL_STEPS - 1)) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // configuration registers and level state
  always_ff @(posedge clk) begin
    if (rst) begin
      coef          <= COEF_RESET;
      floor_cfg     <= FLOOR_RESET;
      running_level <= LEVEL_RESET;
    end else begin
      if (cfg_write && cfg_index == REG_COEF) begin
        coef <= cfg_data[COEF_W-1:0];
      end
      if (cfg_write && cfg_index == REG_FLOOR) begin
        floor_cfg <= cfg_data[FLOOR_W-1:0];
      end
      if (fin_fire) begin
        running_level <= nv;
      end
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          sample_mag <= mag_in;
          eob        <= end_of_block;
          lvl        <= (running_level < flr) ? flr : running_level;
        end
      end
      ST_SQUARE: begin
        dq  <= {sq, 2'b00};
        rem <= '0;
        cnt <= '0;
      end
      ST_DIVIDE: begin
        dq  <= {dq[QUO_W-3:0], q1, q2};
        rem <= r2[LEVEL_W-1:0];
        cnt <= cnt + CNT_W'(1);
      end
      ST_DIFF: begin
        d_pos <= (dq >= {(QUO_W - LEVEL_W)'(0), lvl});
        dmag  <= (dq >= {(QUO_W - LEVEL_W)'(0), lvl})
                 ? (dq - {(QUO_W - LEVEL_W)'(0), lvl})
                 : ({(QUO_W - LEVEL_W)'(0), lvl} - dq);
      end
      ST_TRIPLE: begin
        d3      <= {2'b00, dmag} + {1'b0, dmag, 1'b0};
        acc     <= '0;
        coef_sh <= coef;
        cnt     <= '0;
      end
      ST_MULT: begin
        acc     <= {2'b00, mul_sum[ACC_W-1:2]};
        coef_sh <= {2'b00, coef_sh[COEF_W-1:2]};
        cnt     <= cnt + CNT_W'(1);
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      level      <= nv;
      block_done <= eob;
    end
  end

endmodule

@@ hw/rtl/rlf_checker.sv @@
module rlf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic        [rlf_pkg::LEVEL_W-1:0]  level,
  input logic                                block_done
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(level) && $stable(block_done))
    else $error("result changed while stalled");

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block idle right after accepting an item");

  // a new result only comes out of work in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in progress");

  // level never underflows to zero: the floor keeps it at one or more
  a_level_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level != '0)
    else $error("level reached zero");

endmodule

bind rms_level_follower_unit rlf_checker u_rlf_checker (.*);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rlf_pkg::*;

  // run shape
  localparam int DRAIN_WAIT     = 60;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int PHASES         = 7;

  // indexes with no register behind them
  localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [LEVEL_W-1:0] lvl;
    logic               done;
  } level_item_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       end_of_block = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic        [LEVEL_W-1:0]  level;
  logic                       block_done;
  logic                       cfg_write = 1'b0;
  logic        [IDX_W-1:0]    cfg_index = '0;
  logic        [CFG_W-1:0]    cfg_data = '0;

  // expected levels in order, and the tracked follower state
  level_item_t        level_q[$];
  logic [LEVEL_W-1:0] trk_level = LEVEL_RESET;
  logic [COEF_W-1:0]  trk_coef  = COEF_RESET;
  logic [FLOOR_W-1:0] trk_floor = FLOOR_RESET;

  bit gaps_on      = 1'b1;
  int fail_count   = 0;
  int quiet_cycles = 0;
  int stall_run    = 0;

  rms_level_follower_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .end_of_block (end_of_block),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level        (level),
    .block_done   (block_done),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one leaky-integrator newton step on the tracked level
  function automatic logic [LEVEL_W-1:0] track_rms(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] mag;
    logic [FLOOR_W-1:0]  flr;
    logic [63:0]         lv, q, d;
    logic [88:0]         prod;
    logic [64:0]         m, nv;
    mag = s[SAMPLE_W-1] ? (~s + SAMPLE_W'(1)) : s;
    flr = (trk_floor == '0) ? FLOOR_W'(1) : trk_floor;
    if (trk_level < flr) trk_level = LEVEL_W'(flr);
    lv = 64'(trk_level);
    // x^2 in q2.46, times 4 over a q8.24 level gives q8.24
    q = (64'(mag) * 64'(mag) * 64'd4) / lv;
    if (q >= lv) begin
      d = q - lv;
      prod = 89'(trk_coef) * 89'(d);
      m = prod[88:24];
      nv = 65'(lv) + m;
      if (nv > 65'hFFFF_FFFF) nv = 65'hFFFF_FFFF;
    end else begin
      d = lv - q;
      prod = 89'(trk_coef) * 89'(d);
      m = prod[88:24];
      nv = (m >= 65'(lv)) ? 65'd0 : 65'(lv) - m;
    end
    trk_level = nv[LEVEL_W-1:0];
    return trk_level;
  endfunction

  // mostly scaled-down audio, some full scale, a few rail values
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    logic signed [SAMPLE_W-1:0] v;
    r = $urandom_range(0, 99);
    v = SAMPLE_W'($urandom);
    if (r < 4) v = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    else if (r < 70) v = v >>> $urandom_range(0, 20);
    return v;
  endfunction

  // present one item, hold it until taken, then record its level
  task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic eob);
    if (gaps_on && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 99) < 15) ? $urandom_range(4, 50) : $urandom_range(1, 3))
        @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample       <= s;
    end_of_block <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    level_q.push_back('{lvl: track_rms(s), done: eob});
  endtask

  // stop sending and let every pending level come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_COEF) trk_coef = val[COEF_W-1:0];
    else if (idx == REG_FLOOR) trk_floor = val;
  endtask

  // reset coefficient and floor, rail samples
  task automatic test_reset_state();
    send_item(24'sh000000, 1'b0);
    send_item(24'sh7FFFFF, 1'b1);
    send_item(24'sh800000, 1'b0);
    send_item(24'shFFFFFF, 1'b1);
  endtask

  // coefficient above one half on a tiny floor drives the level to saturation
  task automatic test_level_saturation();
    drain_results();
    write_reg(REG_COEF, 25'h0FFFFFF);
    write_reg(REG_FLOOR, 25'd1);
    send_item(24'sh7FFFFF, 1'b0);
    send_item(24'sh800000, 1'b1);
    send_item(24'sh800000, 1'b0);
    send_item(24'sh000000, 1'b1);
    send_item(24'sh000001, 1'b0);
    send_item(24'shFFFFFF, 1'b0);
  endtask

  // zero floor must behave as a floor of one
  task automatic test_floor_zero();
    drain_results();
    write_reg(REG_FLOOR, 25'd0);
    send_item(24'sh000000, 1'b0);
    send_item(24'sh000000, 1'b0);
    send_item(24'sh000000, 1'b1);
    send_item(24'sh000001, 1'b0);
    send_item(24'shFFFFFF, 1'b1);
  endtask

  // zero coefficient freezes the level, first at a high floor, then above a lower floor
  task automatic test_coef_zero_high_floor();
    drain_results();
    write_reg(REG_COEF, 25'd0);
    write_reg(REG_FLOOR, 25'h1FFFFFF);
    send_item(pick_sample(), 1'b0);
    send_item(24'sh7FFFFF, 1'b0);
    send_item(pick_sample(), 1'b1);
    drain_results();
    write_reg(REG_FLOOR, 25'h1000000);
    send_item(pick_sample(), 1'b0);
    send_item(24'sh800000, 1'b1);
  endtask

  // writes to unused indexes change nothing
  task automatic test_unused_index();
    drain_results();
    write_reg(REG_SPARE_2, 25'h1FFFFFF);
    write_reg(REG_SPARE_3, 25'h0000000);
    send_item(pick_sample(), 1'b0);
    send_item(pick_sample(), 1'b1);
  endtask

  // random streams over several register settings
  task automatic test_random_stream();
    int per_phase;
    logic [CFG_W-1:0] cv, fv;
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          cv = CFG_W'(COEF_RESET);
          fv = FLOOR_RESET;
        end
        1: begin
          cv = 25'h0800000;
          fv = 25'd1;
        end
        2: begin
          cv = CFG_W'($urandom_range(1, 8388608));
          fv = CFG_W'($urandom_range(1, 16777216));
        end
        3: begin
          cv = {1'($urandom_range(0, 1)), 24'hFFFFFF};
          fv = 25'h1FFFFFF;
        end
        4: begin
          cv = 25'd0;
          fv = 25'd0;
        end
        5: begin
          cv = CFG_W'($urandom);
          fv = CFG_W'($urandom);
        end
        default: begin
          cv = CFG_W'($urandom_range(0, 8388608));
          fv = CFG_W'($urandom_range(0, 65535));
        end
      endcase
      write_reg(REG_COEF, cv);
      write_reg(REG_FLOOR, fv);
      // one phase runs with no idling on either side
      gaps_on = (p != 3);
      for (int i = 0; i < per_phase; i++) begin
        send_item(pick_sample(), $urandom_range(0, 7) == 0);
        if (p == 2 && i == per_phase / 2) drain_results();
      end
    end
    gaps_on = 1'b1;
  endtask

  // stall generator for the result side, with occasional long holds
  always @(posedge clk) begin : stall_gen
    int unsigned r;
    r = $urandom_range(0, 999);
    if (stall_run > 0) stall_run = stall_run - 1;
    else if (gaps_on && r < 2) stall_run = $urandom_range(30, 120);
    else if (gaps_on && r < 80) stall_run = 1;
    out_stall <= (stall_run > 0);
  end

  // compare each taken level against the oldest expectation, and watchdog
  always @(posedge clk) begin : result_check
    level_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (level_q.size() == 0) begin
          $error("unexpected item: level %0d block_done %0d", level, block_done);
          fail_count++;
        end else begin
          want = level_q.pop_front();
          if (level !== want.lvl) begin
            $error("level: expected %0d, got %0d", want.lvl, level);
            fail_count++;
          end
          if (block_done !== want.done) begin
            $error("block_done: expected %0d, got %0d", want.done, block_done);
            fail_count++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_level_saturation();
    test_floor_zero();
    test_coef_zero_high_floor();
    test_unused_index();
    test_random_stream();
    drain_results();
    if (fail_count == 0 && level_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
